// ===== src/cigar_span_clip_overlap_counter_core_macros.svh =====
// Assertion macros shared by the CIGAR span counter modules.
`ifndef CIGAR_SPAN_CLIP_OVERLAP_COUNTER_CORE_MACROS_SVH
`define CIGAR_SPAN_CLIP_OVERLAP_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CSCOC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cscoc: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define CSCOC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cscoc: next-cycle check failed");

`endif

// ===== src/cscoc_pkg.sv =====
// Shared types, codes and helpers for the CIGAR span, clip and overlap counter.
package cscoc_pkg;

  // Operation kinds. Codes above KIND_PAD behave like KIND_NONE.
  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_MATCH    = 4'd1;
  localparam logic [3:0] KIND_MISMATCH = 4'd2;
  localparam logic [3:0] KIND_INSERT   = 4'd3;
  localparam logic [3:0] KIND_DELETION = 4'd4;
  localparam logic [3:0] KIND_SKIP     = 4'd5;
  localparam logic [3:0] KIND_SOFT     = 4'd6;
  localparam logic [3:0] KIND_HARD     = 4'd7;
  localparam logic [3:0] KIND_PAD      = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_REGION_START   = 2'd0;
  localparam logic [1:0] REG_REGION_END     = 2'd1;
  localparam logic [1:0] REG_READ_START_POS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] REGION_START_RESET   = 32'h0000_0000;
  localparam logic [31:0] REGION_END_RESET     = 32'hFFFF_FFFF;
  localparam logic [31:0] READ_START_POS_RESET = 32'h0000_0000;

  // Region end code that leaves the region open.
  localparam logic [31:0] REGION_END_OPEN = 32'hFFFF_FFFF;

  // One CIGAR operation.
  typedef struct packed {
    logic [3:0]  op_kind;
    logic [27:0] op_length;
    logic        op_last;
  } op_item_t;

  // Counts reported at the end of a CIGAR.
  typedef struct packed {
    logic [31:0] query_length;
    logic [31:0] reference_length;
    logic [31:0] leading_clips;
    logic [31:0] trailing_clips;
    logic [31:0] overlap_count;
  } result_t;

  // Region bounds as reference offsets from the alignment start.
  typedef struct packed {
    logic signed [33:0] lo_off;
    logic signed [33:0] end_off;
    logic               open;
  } region_t;

  // Saturating add of an operation length onto a 32-bit sum.
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [27:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {5'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== src/cscoc_overlap.sv =====
// Number of bases of one aligned operation that fall inside the region.
module cscoc_overlap (
  input  logic [31:0]        ref_offset,
  input  logic [27:0]        op_length,
  input  cscoc_pkg::region_t region,
  output logic [27:0]        count
);

  logic signed [33:0] r0;
  logic signed [33:0] hi_op;
  logic signed [33:0] lo;
  logic signed [33:0] hi;
  logic signed [33:0] diff;

  // Intersect [r0, r0 + len) with [lo_off, end_off).
  always_comb begin
    r0    = $signed({2'b00, ref_offset});
    hi_op = r0 + $signed({6'b0, op_length});
    lo    = (region.lo_off > r0) ? region.lo_off : r0;
    hi    = (!region.open && (region.end_off < hi_op)) ? region.end_off : hi_op;
    diff  = hi - lo;
    count = (hi > lo) ? diff[27:0] : 28'd0;
  end

endmodule

// ===== src/cscoc_accum.sv =====
// Running sums of one CIGAR and the counts they give after each operation.
`include "cigar_span_clip_overlap_counter_core_macros.svh"

module cscoc_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  cscoc_pkg::op_item_t item,
  input  cscoc_pkg::region_t  region,
  output cscoc_pkg::result_t  sums_next
);

  logic [31:0] query_total;
  logic [31:0] ref_total;
  logic [31:0] leading_total;
  logic        still_leading;
  logic [31:0] trailing_total;
  logic [31:0] overlap_total;

  logic        still_leading_next;
  logic        is_aligned;
  logic        is_query;
  logic        is_ref;
  logic        is_clip;
  logic [27:0] op_overlap;

  cscoc_overlap u_overlap (
    .ref_offset (ref_total),
    .op_length  (item.op_length),
    .region     (region),
    .count      (op_overlap)
  );

  // Decode which sums this operation feeds; unknown kinds feed none.
  always_comb begin
    is_aligned = (item.op_kind == cscoc_pkg::KIND_MATCH) ||
                 (item.op_kind == cscoc_pkg::KIND_MISMATCH);
    is_query   = is_aligned || (item.op_kind == cscoc_pkg::KIND_INSERT) ||
                 (item.op_kind == cscoc_pkg::KIND_SOFT);
    is_ref     = is_aligned || (item.op_kind == cscoc_pkg::KIND_DELETION) ||
                 (item.op_kind == cscoc_pkg::KIND_SKIP);
    is_clip    = (item.op_kind == cscoc_pkg::KIND_SOFT) ||
                 (item.op_kind == cscoc_pkg::KIND_HARD);
  end

  // Sums including the current operation.
  always_comb begin
    sums_next.query_length     = is_query ? cscoc_pkg::sat_add(query_total, item.op_length)
                                          : query_total;
    sums_next.reference_length = is_ref ? cscoc_pkg::sat_add(ref_total, item.op_length)
                                        : ref_total;
    sums_next.overlap_count    = is_aligned ? cscoc_pkg::sat_add(overlap_total, op_overlap)
                                            : overlap_total;
    if (is_clip) begin
      sums_next.leading_clips  = still_leading ?
                                 cscoc_pkg::sat_add(leading_total, item.op_length) :
                                 leading_total;
      sums_next.trailing_clips = cscoc_pkg::sat_add(trailing_total, item.op_length);
      still_leading_next       = still_leading;
    end else begin
      sums_next.leading_clips  = leading_total;
      sums_next.trailing_clips = 32'd0;
      still_leading_next       = 1'b0;
    end
  end

  // Update on each processed operation; the last one starts a new CIGAR.
  always_ff @(posedge clk) begin
    if (rst || (fire && item.op_last)) begin
      query_total    <= 32'd0;
      ref_total      <= 32'd0;
      leading_total  <= 32'd0;
      still_leading  <= 1'b1;
      trailing_total <= 32'd0;
      overlap_total  <= 32'd0;
    end else if (fire) begin
      query_total    <= sums_next.query_length;
      ref_total      <= sums_next.reference_length;
      leading_total  <= sums_next.leading_clips;
      still_leading  <= still_leading_next;
      trailing_total <= sums_next.trailing_clips;
      overlap_total  <= sums_next.overlap_count;
    end
  end

  // While only clips have been seen, both clip runs are the same run.
  `CSCOC_ASSERT_IMP(a_clip_runs_agree, still_leading, leading_total == trailing_total)
  // Overlap bases are a subset of the reference span.
  `CSCOC_ASSERT_IMP(a_overlap_in_span, 1'b1, overlap_total <= ref_total)
  // The last operation leaves cleared sums behind.
  `CSCOC_ASSERT_NXT(a_clear_on_last, fire && item.op_last,
                    (query_total == 32'd0) && (ref_total == 32'd0) && still_leading)

endmodule

// ===== src/cigar_span_clip_overlap_counter_core.sv =====
// CIGAR span, clip and overlap counter: takes one operation per cycle unless stalled, one result per CIGAR.
// The result register loads the sums when the last operation of a CIGAR leaves the input register.
// Throughput: one operation per cycle, except while a last operation waits for the result register.
// A last operation waits in the input register while an earlier result is unaccepted.
// Reset (rst, synchronous) clears all sums, empties both registers and restores the
// configuration registers to region_start 0, region_end -1 (open) and read_start_pos 0.
`include "cigar_span_clip_overlap_counter_core_macros.svh"

module cigar_span_clip_overlap_counter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cscoc_pkg::op_item_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cscoc_pkg::result_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  logic [31:0]         region_start;
  logic [31:0]         region_end;
  logic [31:0]         read_start_pos;
  cscoc_pkg::region_t  region;
  cscoc_pkg::op_item_t stage;
  logic                stage_valid;
  logic                stage_advance;
  logic                fire;
  cscoc_pkg::result_t  sums_next;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start   <= cscoc_pkg::REGION_START_RESET;
      region_end     <= cscoc_pkg::REGION_END_RESET;
      read_start_pos <= cscoc_pkg::READ_START_POS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cscoc_pkg::REG_REGION_START:   region_start   <= cfg_data;
        cscoc_pkg::REG_REGION_END:     region_end     <= cfg_data;
        cscoc_pkg::REG_READ_START_POS: read_start_pos <= cfg_data;
        default: ;
      endcase
    end
  end

  // Region bounds as offsets from the alignment start, kept in registers.
  always_ff @(posedge clk) begin
    region.lo_off  <= $signed({{2{region_start[31]}}, region_start}) -
                      $signed({{2{read_start_pos[31]}}, read_start_pos});
    region.end_off <= $signed({{2{region_end[31]}}, region_end}) -
                      $signed({{2{read_start_pos[31]}}, read_start_pos});
    region.open    <= (region_end == cscoc_pkg::REGION_END_OPEN);
  end

  // A staged operation moves on unless it must hand a result to a full output register.
  assign stage_advance = !stage.op_last || !out_valid || out_ready;
  assign fire          = stage_valid && stage_advance;
  assign in_ready      = !stage_valid || stage_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= in_data;
    end
  end

  cscoc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (stage),
    .region    (region),
    .sums_next (sums_next)
  );

  // Result register, loaded by the last operation of a CIGAR.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && stage.op_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stage.op_last) begin
      out_data <= sums_next;
    end
  end

  // A result only appears after a last operation was processed.
  `CSCOC_ASSERT_IMP(a_result_from_last, $rose(out_valid), $past(fire && stage.op_last))
  // A last operation waits in the input register while the result is blocked.
  `CSCOC_ASSERT_NXT(a_last_holds, stage_valid && stage.op_last && out_valid && !out_ready,
                    stage_valid && $stable(stage))
  // Reported overlap never exceeds the reported reference span.
  `CSCOC_ASSERT_IMP(a_out_overlap, out_valid,
                    out_data.overlap_count <= out_data.reference_length)

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the CIGAR span, clip and overlap counter.
`timescale 1ns / 100ps

module tb;

  // Codes above pad are undefined and must act like none.
  localparam logic [3:0] KIND_UNDEFINED = 4'hF;
  localparam logic [27:0] LEN_MAX = 28'hFFF_FFFF;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  cscoc_pkg::op_item_t in_data;
  logic                out_valid;
  logic                out_ready;
  cscoc_pkg::result_t  out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [31:0]         cfg_data;

  cigar_span_clip_overlap_counter_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the configuration registers, at their reset values.
  logic [31:0] region_lo = cscoc_pkg::REGION_START_RESET;
  logic [31:0] region_hi = cscoc_pkg::REGION_END_RESET;
  logic [31:0] align_pos = cscoc_pkg::READ_START_POS_RESET;

  // Running sums of the CIGAR in progress.
  logic [31:0] qry_sum = '0;
  logic [31:0] span_sum = '0;
  logic [31:0] lead_sum = '0;
  logic [31:0] trail_sum = '0;
  logic [31:0] ovl_sum = '0;
  bit          in_lead = 1'b1;

  cscoc_pkg::result_t expected_counts[$];

  int  errors = 0;
  int  ops_sent = 0;
  int  cigars_checked = 0;
  int  settings_applied = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  int  hold_cycles = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard against a hung run.
  initial begin
    #5_000_000;
    $display("%0t: run timed out with %0d results outstanding", $time, expected_counts.size());
    $display("== FAIL ==");
    $finish;
  end

  // Add onto a 32-bit running sum, saturating at all ones.
  function automatic logic [31:0] clamp_add(logic [31:0] a, longint b);
    longint s;
    s = longint'(a) + b;
    return (s > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Aligned bases at reference offsets [r0, r0 + len) that fall inside the region.
  function automatic longint region_bases(logic [31:0] r0, logic [27:0] len);
    longint base;
    longint lo;
    longint hi;
    longint stop;
    base = longint'($signed(align_pos));
    lo = longint'($signed(region_lo)) - base;
    hi = longint'(r0) + longint'(len);
    if (lo < longint'(r0)) lo = longint'(r0);
    if (region_hi != cscoc_pkg::REGION_END_OPEN) begin
      stop = longint'($signed(region_hi)) - base;
      if (stop < hi) hi = stop;
    end
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Fold one accepted operation into the sums; a last operation queues the counts.
  task automatic tally_cigar_op(input cscoc_pkg::op_item_t op);
    bit                 aligned;
    bit                 is_clip;
    cscoc_pkg::result_t counts;
    aligned = (op.op_kind == cscoc_pkg::KIND_MATCH) ||
              (op.op_kind == cscoc_pkg::KIND_MISMATCH);
    is_clip = (op.op_kind == cscoc_pkg::KIND_SOFT) || (op.op_kind == cscoc_pkg::KIND_HARD);
    if (aligned) ovl_sum = clamp_add(ovl_sum, region_bases(span_sum, op.op_length));
    if (aligned || op.op_kind == cscoc_pkg::KIND_INSERT || op.op_kind == cscoc_pkg::KIND_SOFT)
      qry_sum = clamp_add(qry_sum, op.op_length);
    if (aligned || op.op_kind == cscoc_pkg::KIND_DELETION ||
        op.op_kind == cscoc_pkg::KIND_SKIP)
      span_sum = clamp_add(span_sum, op.op_length);
    if (is_clip) begin
      if (in_lead) lead_sum = clamp_add(lead_sum, op.op_length);
      trail_sum = clamp_add(trail_sum, op.op_length);
    end else begin
      in_lead = 1'b0;
      trail_sum = '0;
    end
    if (op.op_last) begin
      counts.query_length     = qry_sum;
      counts.reference_length = span_sum;
      counts.leading_clips    = lead_sum;
      counts.trailing_clips   = trail_sum;
      counts.overlap_count    = ovl_sum;
      expected_counts = {expected_counts, counts};
      qry_sum   = '0;
      span_sum  = '0;
      lead_sum  = '0;
      trail_sum = '0;
      ovl_sum   = '0;
      in_lead   = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
               $time, name, want, want, got, got);
      errors++;
    end
  endtask

  // Observe every transaction on all three channels.
  always @(posedge clk) begin
    cscoc_pkg::result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cscoc_pkg::REG_REGION_START:   region_lo = cfg_data;
          cscoc_pkg::REG_REGION_END:     region_hi = cfg_data;
          cscoc_pkg::REG_READ_START_POS: align_pos = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) tally_cigar_op(in_data);
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result, expected none, got 0x%h", $time, out_data);
          errors++;
        end else begin
          want = expected_counts.pop_front();
          check_field("query_length", want.query_length, out_data.query_length);
          check_field("reference_length", want.reference_length, out_data.reference_length);
          check_field("leading_clips", want.leading_clips, out_data.leading_clips);
          check_field("trailing_clips", want.trailing_clips, out_data.trailing_clips);
          check_field("overlap_count", want.overlap_count, out_data.overlap_count);
          cigars_checked++;
        end
      end
    end
  end

  // Result receiver: random stall before each transaction, or a long hold on request.
  initial begin
    int n;
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = rx_calm ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid && hold_cycles == 0) @(posedge clk);
    end
  end

  function automatic cscoc_pkg::op_item_t mk_op(logic [3:0] kind, logic [27:0] len, logic last);
    cscoc_pkg::op_item_t op;
    op.op_kind   = kind;
    op.op_length = len;
    op.op_last   = last;
    return op;
  endfunction

  // Mostly short lengths, with an occasional one across the whole field.
  function automatic logic [27:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 28'($urandom_range(0, 200));
    if (r < 90) return 28'($urandom_range(0, 5000));
    return 28'($urandom_range(0, LEN_MAX));
  endfunction

  function automatic logic [3:0] pick_body_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return cscoc_pkg::KIND_MATCH;
    if (r < 52) return cscoc_pkg::KIND_MISMATCH;
    if (r < 62) return cscoc_pkg::KIND_INSERT;
    if (r < 72) return cscoc_pkg::KIND_DELETION;
    if (r < 80) return cscoc_pkg::KIND_SKIP;
    if (r < 86) return cscoc_pkg::KIND_PAD;
    if (r < 90) return cscoc_pkg::KIND_NONE;
    if (r < 93) return cscoc_pkg::KIND_SOFT;
    if (r < 96) return cscoc_pkg::KIND_HARD;
    return cscoc_pkg::KIND_PAD + 4'($urandom_range(1, 7));
  endfunction

  // Offer one operation and wait for its transaction.
  task automatic send_op(input cscoc_pkg::op_item_t op);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= op;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ops_sent++;
  endtask

  // Let the block run dry: every result in, then the pipeline latency.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers once the block is idle.
  task automatic program_region(input logic [31:0] start_pos, end_pos, read_pos);
    logic [31:0] vals[3];
    logic [1:0]  idx[3];
    drain();
    vals = '{start_pos, end_pos, read_pos};
    idx  = '{cscoc_pkg::REG_REGION_START, cscoc_pkg::REG_REGION_END,
             cscoc_pkg::REG_READ_START_POS};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // A CIGAR shaped like a real alignment, or now and then pure noise.
  task automatic send_random_cigar();
    cscoc_pkg::op_item_t ops[$];
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) ops = {ops, mk_op(4'($urandom_range(0, 15)), pick_len(), 1'b0)};
    end else begin
      repeat ($urandom_range(0, 2))
        ops = {ops, mk_op($urandom_range(0, 1) ? cscoc_pkg::KIND_SOFT : cscoc_pkg::KIND_HARD,
                          pick_len(), 1'b0)};
      repeat ($urandom_range(0, 6)) ops = {ops, mk_op(pick_body_kind(), pick_len(), 1'b0)};
      repeat ($urandom_range(0, 2))
        ops = {ops, mk_op($urandom_range(0, 1) ? cscoc_pkg::KIND_SOFT : cscoc_pkg::KIND_HARD,
                          pick_len(), 1'b0)};
      if (ops.size() == 0) ops = {ops, mk_op(cscoc_pkg::KIND_MATCH, pick_len(), 1'b0)};
    end
    ops[ops.size() - 1].op_last = 1'b1;
    foreach (ops[i]) send_op(ops[i]);
  endtask

  task automatic run_random_cigars(input int n_ops);
    int stop_at;
    stop_at = ops_sent + n_ops;
    while (ops_sent < stop_at) send_random_cigar();
  endtask

  // Field extremes, every kind, undefined kinds, zero lengths, clip-only reads
  // and the two region edges relative to the alignment start.
  task automatic test_directed_ops();
    cscoc_pkg::op_item_t ops[$];
    ops = '{
      mk_op(cscoc_pkg::KIND_MATCH, LEN_MAX, 1'b1),
      mk_op(cscoc_pkg::KIND_MATCH, 28'd0, 1'b1),
      mk_op(cscoc_pkg::KIND_SOFT, 28'd5, 1'b0), mk_op(cscoc_pkg::KIND_HARD, 28'd3, 1'b0),
      mk_op(cscoc_pkg::KIND_MATCH, 28'd10, 1'b0), mk_op(cscoc_pkg::KIND_MISMATCH, 28'd4, 1'b0),
      mk_op(cscoc_pkg::KIND_INSERT, 28'd2, 1'b0), mk_op(cscoc_pkg::KIND_DELETION, 28'd3, 1'b0),
      mk_op(cscoc_pkg::KIND_SKIP, 28'd7, 1'b0), mk_op(cscoc_pkg::KIND_PAD, 28'd1, 1'b0),
      mk_op(cscoc_pkg::KIND_NONE, 28'd0, 1'b0), mk_op(cscoc_pkg::KIND_SOFT, 28'd2, 1'b0),
      mk_op(cscoc_pkg::KIND_HARD, 28'd1, 1'b1),
      mk_op(cscoc_pkg::KIND_SOFT, 28'd4, 1'b0), mk_op(KIND_UNDEFINED, 28'd9, 1'b0),
      mk_op(cscoc_pkg::KIND_HARD, 28'd2, 1'b1),
      mk_op(cscoc_pkg::KIND_HARD, 28'd0, 1'b0), mk_op(cscoc_pkg::KIND_MATCH, 28'd0, 1'b0),
      mk_op(cscoc_pkg::KIND_SOFT, 28'd0, 1'b1),
      mk_op(cscoc_pkg::KIND_SOFT, 28'd7, 1'b0), mk_op(cscoc_pkg::KIND_HARD, 28'd8, 1'b1)
    };
    foreach (ops[i]) send_op(ops[i]);
    // Region starts before the read and ends inside the first match.
    program_region(32'd10, 32'd30, 32'd20);
    send_op(mk_op(cscoc_pkg::KIND_MATCH, 28'd15, 1'b0));
    send_op(mk_op(cscoc_pkg::KIND_DELETION, 28'd5, 1'b0));
    send_op(mk_op(cscoc_pkg::KIND_MATCH, 28'd20, 1'b1));
    // Region ends before the read starts.
    program_region(32'd0, 32'd5, 32'd20);
    send_op(mk_op(cscoc_pkg::KIND_MATCH, 28'd10, 1'b1));
    drain();
  endtask

  // Reference span that passes 2^32 - 1 around a region near the top offset.
  task automatic send_span_past_saturation();
    repeat (16) send_op(mk_op(cscoc_pkg::KIND_SKIP, LEN_MAX, 1'b0));
    send_op(mk_op(cscoc_pkg::KIND_MATCH, 28'd100, 1'b0));
    repeat (2) send_op(mk_op(cscoc_pkg::KIND_SKIP, LEN_MAX, 1'b0));
    send_op(mk_op(cscoc_pkg::KIND_MISMATCH, 28'd50, 1'b1));
  endtask

  task automatic test_saturation();
    program_region(cscoc_pkg::REGION_START_RESET, cscoc_pkg::REGION_END_OPEN,
                   cscoc_pkg::READ_START_POS_RESET);
    repeat (16) send_op(mk_op(cscoc_pkg::KIND_MATCH, LEN_MAX, 1'b0));
    send_op(mk_op(cscoc_pkg::KIND_MATCH, LEN_MAX, 1'b1));
    repeat (16) send_op(mk_op(cscoc_pkg::KIND_SOFT, LEN_MAX, 1'b0));
    send_op(mk_op(cscoc_pkg::KIND_HARD, LEN_MAX, 1'b1));
    program_region(32'h7FFF_FFF0, cscoc_pkg::REGION_END_OPEN, 32'h8000_0000);
    send_span_past_saturation();
    program_region(32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_span_past_saturation();
    drain();
  endtask

  // Registers change between two operations of one CIGAR.
  task automatic test_config_mid_cigar();
    program_region(32'd0, cscoc_pkg::REGION_END_OPEN, 32'd0);
    send_op(mk_op(cscoc_pkg::KIND_MATCH, 28'd50, 1'b0));
    program_region(32'd100, cscoc_pkg::REGION_END_OPEN, 32'd0);
    send_op(mk_op(cscoc_pkg::KIND_MATCH, 28'd50, 1'b0));
    program_region(32'd60, 32'd200, 32'hFFFF_FFF6);
    send_op(mk_op(cscoc_pkg::KIND_MATCH, 28'd80, 1'b1));
    drain();
  endtask

  // Fixed settings, the extremes of each register among them.
  task automatic test_region_settings();
    logic [31:0] starts[6];
    logic [31:0] ends[6];
    logic [31:0] poss[6];
    starts = '{cscoc_pkg::REGION_START_RESET, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF,
               32'hFFFF_FC18, 32'd300};
    ends   = '{cscoc_pkg::REGION_END_RESET, 32'd400, 32'h7FFF_FFFF,
               cscoc_pkg::REGION_END_OPEN, 32'd0, 32'd300};
    poss   = '{cscoc_pkg::READ_START_POS_RESET, 32'd50, 32'h7FFF_FFFF, 32'h8000_0000,
               32'hFFFF_EC78, 32'd0};
    foreach (starts[i]) begin
      program_region(starts[i], ends[i], poss[i]);
      run_random_cigars(120);
    end
    drain();
  endtask

  // Random settings, mostly with the region near the read so overlaps are partial.
  task automatic test_random_regions();
    logic [31:0] pos;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    for (int k = 0; k < 4; k++) begin
      pos = $urandom();
      if (k == 0) begin
        start_pos = $urandom();
        end_pos = $urandom() & 32'h7FFF_FFFF;
      end else begin
        start_pos = pos + $urandom_range(0, 3000) - 32'd500;
        end_pos = ($urandom_range(0, 3) == 0) ? cscoc_pkg::REGION_END_OPEN
                                              : start_pos + $urandom_range(0, 4000);
        if (end_pos[31] && end_pos != cscoc_pkg::REGION_END_OPEN)
          end_pos = cscoc_pkg::REGION_END_OPEN;
      end
      program_region(start_pos, end_pos, pos);
      run_random_cigars(100);
    end
    drain();
  endtask

  // Full rate on both sides.
  task automatic test_back_to_back();
    program_region(32'd0, 32'd2000, 32'hFFFF_FF00);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_random_cigars(150);
    drain();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Receiver holds off long enough that the block fills and stalls its input.
  task automatic test_output_backpressure();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    hold_cycles = 400;
    repeat (30) send_op(mk_op(pick_body_kind(), pick_len(), 1'b1));
    drain();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= cscoc_pkg::REG_REGION_START;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_ops();
    test_saturation();
    test_config_mid_cigar();
    test_region_settings();
    test_random_regions();
    test_back_to_back();
    test_output_backpressure();
    drain();

    if (expected_counts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_counts.size());
      errors++;
    end
    $display("Sent %0d CIGAR operations and checked %0d CIGAR results under %0d region settings,",
             ops_sent, cigars_checked, settings_applied);
    $display("with random gaps, full-rate bursts and a long output stall; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== cigar_span_clip_overlap_counter_core.f =====
+incdir+src
src/cscoc_pkg.sv
src/cscoc_overlap.sv
src/cscoc_accum.sv
src/cigar_span_clip_overlap_counter_core.sv
tb/sv/tb.sv
